// ----- rtl/cif_pkg.sv -----
// shared types, constants and the crc-32 byte update for the chunked image framer
`default_nettype none

package cif_pkg;

   // default width of the image length field
   localparam int CIF_LENGTH_BITS = 24;

   // frame marker and version bytes
   localparam logic [7:0] SYNC_HI = 8'hAA;
   localparam logic [7:0] SYNC_LO = 8'h55;
   localparam logic [7:0] VERSION = 8'h01;

   // crc-32 ieee, reflected
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   // register reset values and indexes (paddr bit 2)
   localparam logic [15:0] CHUNK_SIZE_RST = 16'd1024;
   localparam logic [7:0]  FRAME_TYPE_RST = 8'd1;
   localparam logic        REG_CHUNK_SIZE = 1'b0;
   localparam logic        REG_FRAME_TYPE = 1'b1;

   // byte positions within one frame run
   localparam logic [4:0] STEP_SYNC0   = 5'd0;
   localparam logic [4:0] STEP_SYNC1   = 5'd1;
   localparam logic [4:0] STEP_VER     = 5'd2;
   localparam logic [4:0] STEP_TYPE    = 5'd3;
   localparam logic [4:0] STEP_SEQ0    = 5'd4;
   localparam logic [4:0] STEP_SEQ1    = 5'd5;
   localparam logic [4:0] STEP_PLEN0   = 5'd6;
   localparam logic [4:0] STEP_PLEN1   = 5'd7;
   localparam logic [4:0] STEP_PLEN2   = 5'd8;
   localparam logic [4:0] STEP_PLEN3   = 5'd9;
   localparam logic [4:0] STEP_ID      = 5'd10;
   localparam logic [4:0] STEP_CSEQ0   = 5'd11;
   localparam logic [4:0] STEP_CSEQ1   = 5'd12;
   localparam logic [4:0] STEP_TOTAL0  = 5'd13;
   localparam logic [4:0] STEP_TOTAL1  = 5'd14;
   localparam logic [4:0] STEP_DATA    = 5'd15;
   localparam logic [4:0] STEP_CRC0    = 5'd16;
   localparam logic [4:0] STEP_CRC1    = 5'd17;
   localparam logic [4:0] STEP_CRC2    = 5'd18;
   localparam logic [4:0] STEP_CRC3    = 5'd19;
   localparam logic [4:0] STEP_TAIL0   = 5'd20;
   localparam logic [4:0] STEP_TAIL1   = 5'd21;

   // configuration seen by the front end
   typedef struct packed {
      logic [15:0] chunk_size;
      logic [7:0]  frame_type;
   } cfg_type;

   // one classified input byte, front to back
   typedef struct packed {
      logic        err;
      logic        hdr;
      logic        tail;
      logic        done;
      logic [7:0]  data;
      logic [7:0]  ftype;
      logic [15:0] seq;
      logic [16:0] plen;
      logic [7:0]  id;
      logic [15:0] total;
   } cmd_type;

   // crc-32 update by one byte, lsb first
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/cif_queue.sv -----
// two-entry command queue between the front and back ends
`default_nettype none

module cif_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  cif_pkg::cmd_type push_data,
   output logic             full,
   input  wire              pop,
   output cif_pkg::cmd_type pop_data,
   output logic             empty
);
   import cif_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cif_front.sv -----
// front end: accepts image bytes, tracks chunk state and classifies each byte
`default_nettype none

module cif_front #(
   parameter int LENGTH_BITS = cif_pkg::CIF_LENGTH_BITS
) (
   input  wire                   clock,
   input  wire                   reset,
   input  cif_pkg::cfg_type      cfg,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire [7:0]             req_data_byte,
   input  wire [7:0]             req_image_id,
   input  wire [LENGTH_BITS-1:0] req_image_length,
   output logic                  push,
   output cif_pkg::cmd_type      push_data,
   input  wire                   q_full
);
   import cif_pkg::*;

   // compare width and divider width
   localparam int WW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
   localparam int NB = WW + 1;
   localparam int CW = $clog2(NB + 1);

   logic                   in_image_ff, in_image_in;
   logic [7:0]             id_ff, id_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [LENGTH_BITS-1:0] img_off_ff, img_off_in;
   logic [15:0]            chk_off_ff, chk_off_in;
   logic [15:0]            chk_len_ff, chk_len_in;
   logic [15:0]            seq_ff, seq_in;
   logic                   pend_ff, pend_in;
   logic                   pend_err_ff, pend_err_in;
   logic [7:0]             pend_data_ff, pend_data_in;
   logic                   div_busy_ff, div_busy_in;
   logic [CW-1:0]          div_cnt_ff, div_cnt_in;
   logic [NB-1:0]          div_num_ff, div_num_in;
   logic [15:0]            div_rem_ff, div_rem_in;
   logic [15:0]            div_d_ff, div_d_in;

   logic [15:0]            eff_chunk;
   logic [LENGTH_BITS-1:0] rest;
   logic [15:0]            cl_new, cl_use;
   logic                   hdr, tail, done;
   logic [15:0]            chk_next;
   logic [LENGTH_BITS-1:0] img_next;
   logic                   consume, accept;
   logic [16:0]            rem_sh;
   logic                   rem_ge;

   // chunk length and end-of-chunk / end-of-image decisions
   always_comb begin
      eff_chunk = (cfg.chunk_size == 16'd0) ? 16'd1 : cfg.chunk_size;
      rest      = len_ff - img_off_ff;
      cl_new    = (WW'(rest) < WW'(eff_chunk)) ? 16'(rest) : eff_chunk;
      hdr       = (chk_off_ff == 16'd0);
      cl_use    = hdr ? cl_new : chk_len_ff;
      chk_next  = chk_off_ff + 16'd1;
      img_next  = img_off_ff + LENGTH_BITS'(1);
      tail      = (chk_next >= cl_use);
      done      = (img_next >= len_ff);
   end

   assign consume   = pend_ff && !div_busy_ff && !q_full;
   assign req_stall = pend_ff && !consume;
   assign accept    = req_valid && !req_stall;

   // command for the pending byte
   assign push = consume;
   always_comb begin
      push_data       = '0;
      push_data.err   = pend_err_ff;
      push_data.hdr   = !pend_err_ff && hdr;
      push_data.tail  = !pend_err_ff && tail;
      push_data.done  = done;
      push_data.data  = pend_data_ff;
      push_data.ftype = cfg.frame_type;
      push_data.seq   = seq_ff;
      push_data.plen  = {1'b0, cl_use} + 17'd5;
      push_data.id    = id_ff;
      push_data.total = div_num_ff[15:0];
   end

   // divider step: one quotient bit per cycle
   always_comb begin
      rem_sh = {div_rem_ff, div_num_ff[NB-1]};
      rem_ge = (rem_sh >= {1'b0, div_d_ff});
   end

   // next state: consume first, then a newly accepted byte
   always_comb begin
      in_image_in  = in_image_ff;
      id_in        = id_ff;
      len_in       = len_ff;
      img_off_in   = img_off_ff;
      chk_off_in   = chk_off_ff;
      chk_len_in   = chk_len_ff;
      seq_in       = seq_ff;
      pend_in      = pend_ff;
      pend_err_in  = pend_err_ff;
      pend_data_in = pend_data_ff;
      div_busy_in  = div_busy_ff;
      div_cnt_in   = div_cnt_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_d_in     = div_d_ff;

      // retire the pending byte
      if (consume) begin
         pend_in = 1'b0;
         if (!pend_err_ff) begin
            if (hdr) begin
               chk_len_in = cl_new;
            end
            img_off_in = img_next;
            if (tail) begin
               chk_off_in = 16'd0;
               seq_in     = seq_ff + 16'd1;
               if (done) begin
                  in_image_in = 1'b0;
               end
            end else begin
               chk_off_in = chk_next;
            end
         end
      end

      // chunk total divider
      if (div_busy_ff) begin
         div_rem_in = rem_ge ? 16'(rem_sh - {1'b0, div_d_ff}) : rem_sh[15:0];
         div_num_in = {div_num_ff[NB-2:0], rem_ge};
         div_cnt_in = div_cnt_ff - CW'(1);
         if (div_cnt_ff == CW'(1)) begin
            div_busy_in = 1'b0;
         end
      end

      // take a new byte; the first byte of an image latches its header
      if (accept) begin
         pend_in      = 1'b1;
         pend_data_in = req_data_byte;
         pend_err_in  = 1'b0;
         if (!in_image_in) begin
            id_in  = req_image_id;
            len_in = req_image_length;
            if (req_image_length == '0) begin
               pend_err_in = 1'b1;
            end else begin
               in_image_in = 1'b1;
               img_off_in  = '0;
               chk_off_in  = 16'd0;
               seq_in      = 16'd0;
               div_busy_in = 1'b1;
               div_cnt_in  = CW'(NB);
               div_rem_in  = 16'd0;
               div_d_in    = eff_chunk;
               div_num_in  = NB'(req_image_length) + NB'(eff_chunk) - NB'(1);
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_image_ff <= 1'b0;
         pend_ff     <= 1'b0;
         div_busy_ff <= 1'b0;
         chk_off_ff  <= 16'd0;
         seq_ff      <= 16'd0;
      end else begin
         in_image_ff <= in_image_in;
         pend_ff     <= pend_in;
         div_busy_ff <= div_busy_in;
         chk_off_ff  <= chk_off_in;
         seq_ff      <= seq_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      len_ff       <= len_in;
      img_off_ff   <= img_off_in;
      chk_len_ff   <= chk_len_in;
      pend_err_ff  <= pend_err_in;
      pend_data_ff <= pend_data_in;
      div_cnt_ff   <= div_cnt_in;
      div_num_ff   <= div_num_in;
      div_rem_ff   <= div_rem_in;
      div_d_ff     <= div_d_in;
   end

endmodule

`default_nettype wire

// ----- rtl/cif_back.sv -----
// back end: expands each command into frame bytes and keeps the running crc
`default_nettype none

module cif_back (
   input  wire              clock,
   input  wire              reset,
   input  cif_pkg::cmd_type pop_data,
   input  wire              q_empty,
   output logic             pop,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_frame_end,
   output logic             rsp_image_done,
   output logic             rsp_length_error,
   output logic             rsp_run_last
);
   import cif_pkg::*;

   cmd_type     cmd_ff, cmd_in;
   logic        busy_ff, busy_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] crc_ff, crc_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        fend_ff, fend_in;
   logic        done_ff, done_in;
   logic        err_ff, err_in;
   logic        last_ff, last_in;

   logic        out_free, emit, last;
   logic [7:0]  cur_byte;
   logic [31:0] crc_out;

   assign out_free = !valid_ff || !rsp_stall;
   assign emit     = busy_ff && out_free;
   assign pop      = !busy_ff && !q_empty;
   assign crc_out  = crc_ff ^ CRC_INIT;

   // byte for the current position in the frame
   always_comb begin
      case (step_ff)
         STEP_SYNC0:  cur_byte = SYNC_HI;
         STEP_SYNC1:  cur_byte = SYNC_LO;
         STEP_VER:    cur_byte = VERSION;
         STEP_TYPE:   cur_byte = cmd_ff.ftype;
         STEP_SEQ0:   cur_byte = cmd_ff.seq[7:0];
         STEP_SEQ1:   cur_byte = cmd_ff.seq[15:8];
         STEP_PLEN0:  cur_byte = cmd_ff.plen[7:0];
         STEP_PLEN1:  cur_byte = cmd_ff.plen[15:8];
         STEP_PLEN2:  cur_byte = {7'd0, cmd_ff.plen[16]};
         STEP_PLEN3:  cur_byte = 8'd0;
         STEP_ID:     cur_byte = cmd_ff.id;
         STEP_CSEQ0:  cur_byte = cmd_ff.seq[7:0];
         STEP_CSEQ1:  cur_byte = cmd_ff.seq[15:8];
         STEP_TOTAL0: cur_byte = cmd_ff.total[7:0];
         STEP_TOTAL1: cur_byte = cmd_ff.total[15:8];
         STEP_DATA:   cur_byte = cmd_ff.data;
         STEP_CRC0:   cur_byte = crc_out[7:0];
         STEP_CRC1:   cur_byte = crc_out[15:8];
         STEP_CRC2:   cur_byte = crc_out[23:16];
         STEP_CRC3:   cur_byte = crc_out[31:24];
         STEP_TAIL0:  cur_byte = SYNC_LO;
         STEP_TAIL1:  cur_byte = SYNC_HI;
         default:     cur_byte = 8'd0;
      endcase
      if (cmd_ff.err) begin
         cur_byte = 8'd0;
      end
   end

   assign last = cmd_ff.err || (step_ff == STEP_TAIL1) ||
                 ((step_ff == STEP_DATA) && !cmd_ff.tail);

   // sequencer, crc and output register
   always_comb begin
      cmd_in   = cmd_ff;
      busy_in  = busy_ff;
      step_in  = step_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      fend_in  = fend_ff;
      done_in  = done_ff;
      err_in   = err_ff;
      last_in  = last_ff;

      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end

      // load the next command
      if (pop) begin
         cmd_in  = pop_data;
         busy_in = 1'b1;
         step_in = pop_data.hdr ? STEP_SYNC0 : STEP_DATA;
         if (pop_data.hdr) begin
            crc_in = CRC_INIT;
         end
      end

      // one frame byte per cycle unless rsp_stall holds the output
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         err_in   = cmd_ff.err;
         fend_in  = !cmd_ff.err && (step_ff == STEP_TAIL1);
         done_in  = !cmd_ff.err && (step_ff == STEP_TAIL1) && cmd_ff.done;
         last_in  = last;
         step_in  = step_ff + 5'd1;
         if (!cmd_ff.err && (step_ff >= STEP_ID) && (step_ff <= STEP_DATA)) begin
            crc_in = crc32_byte(crc_ff, cur_byte);
         end
         if (!cmd_ff.err && (step_ff == STEP_TAIL1)) begin
            crc_in = CRC_INIT;
         end
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         crc_ff   <= CRC_INIT;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         crc_ff   <= crc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      step_ff <= step_in;
      byte_ff <= byte_in;
      fend_ff <= fend_in;
      done_ff <= done_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_byte   = byte_ff;
   assign rsp_frame_end    = fend_ff;
   assign rsp_image_done   = done_ff;
   assign rsp_length_error = err_ff;
   assign rsp_run_last     = last_ff;

endmodule

`default_nettype wire

// ----- rtl/chunked_image_framer_crc32_top.sv -----
// top level of the chunked image framer with crc-32, with its register block
//
// Image bytes enter on the req_ channel (valid/stall), one beat per byte, with the
// image id and length sampled on an image's first beat. Each beat produces 1 to 22
// result beats on the rsp_ channel: a 15-byte header with the first byte of a chunk,
// the data byte, and crc plus tail with the last byte of a chunk; rsp_run_last marks
// the final result beat of each input beat. A zero image length yields one result
// beat with rsp_length_error set and the input byte is dropped.
// Throughput: one result per cycle while rsp_stall is low; the frame sequencer takes
// its next command only after its current one ends. The first beat of an image also
// waits for the chunk-total divider, one quotient bit per cycle. A two-entry command
// queue sits between front and sequencer, so input beats keep flowing while rsp_stall
// holds a result; req_stall rises once the queue fills or while the divider runs.
// Reset (synchronous, active high) empties the pipeline, ends any open image and
// restores chunk_size to 1024 and frame_type to 1. Registers: chunk_size at byte
// address 0, frame_type at 4; write them only while the block is idle.
`default_nettype none

module chunked_image_framer_crc32_top #(
   parameter int LENGTH_BITS = cif_pkg::CIF_LENGTH_BITS
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire [7:0]             req_data_byte,
   input  wire [7:0]             req_image_id,
   input  wire [LENGTH_BITS-1:0] req_image_length,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [7:0]            rsp_frame_byte,
   output logic                  rsp_frame_end,
   output logic                  rsp_image_done,
   output logic                  rsp_length_error,
   output logic                  rsp_run_last,
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire [2:0]             csr_paddr,
   input  wire [31:0]            csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import cif_pkg::*;

   logic [15:0] chunk_size_ff, chunk_size_in;
   logic [7:0]  frame_type_ff, frame_type_in;
   logic        csr_wr;
   cfg_type     cfg;
   logic        push, pop, q_full, q_empty;
   cmd_type     push_data, pop_data;

   // register block
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      chunk_size_in = chunk_size_ff;
      frame_type_in = frame_type_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_CHUNK_SIZE: chunk_size_in = csr_pwdata[15:0];
            REG_FRAME_TYPE: frame_type_in = csr_pwdata[7:0];
            default:        chunk_size_in = chunk_size_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_CHUNK_SIZE: csr_prdata = {16'd0, chunk_size_ff};
         REG_FRAME_TYPE: csr_prdata = {24'd0, frame_type_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= CHUNK_SIZE_RST;
         frame_type_ff <= FRAME_TYPE_RST;
      end else begin
         chunk_size_ff <= chunk_size_in;
         frame_type_ff <= frame_type_in;
      end
   end

   assign cfg = {chunk_size_ff, frame_type_ff};

   // byte classification and chunk bookkeeping
   cif_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_image_id     (req_image_id),
      .req_image_length (req_image_length),
      .push             (push),
      .push_data        (push_data),
      .q_full           (q_full)
   );

   // decoupling queue
   cif_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // frame byte sequencer
   cif_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_data         (pop_data),
      .q_empty          (q_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_image_done   (rsp_image_done),
      .rsp_length_error (rsp_length_error),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

`default_nettype wire

// ----- rtl/cif_checker.sv -----
// port-level checker for the framer, bound to the top level
`default_nettype none

module cif_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [7:0] rsp_frame_byte,
   input wire       rsp_frame_end,
   input wire       rsp_image_done,
   input wire       rsp_length_error,
   input wire       rsp_run_last
);
   import cif_pkg::*;

   // output register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result beat valid right after reset");

   // a stalled result beat stays valid
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a length error is a lone result and never part of a frame
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |-> rsp_run_last && !rsp_frame_end && !rsp_image_done)
      else $error("length error beat inside a frame");

   // a frame closes with the trailing marker on the last beat of its run
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last && (rsp_frame_byte == SYNC_HI))
      else $error("frame end without trailing marker");

   // image done only on a frame end
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_done |-> rsp_frame_end)
      else $error("image done outside a frame end");

endmodule

bind chunked_image_framer_crc32_top cif_checker u_cif_checker (.*);

`default_nettype wire
